>>> rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, constants and tables for the quaternion to Euler converter.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

  // Width of the trigonometric operands in Q.28 (room for about +-64).
  localparam int QW = 35;
  // Width of the CORDIC datapath, with headroom for the gain.
  localparam int CW = 38;
  // Square root operand and result widths.
  localparam int NW = 58;
  localparam int RW = 29;

  localparam logic signed [QW-1:0] ONE_Q28 = 35'sh010000000;
  localparam logic [31:0] HALF_PI_BA = 32'h40000000;

  // One classified item passed from the front part to the back part.
  typedef struct packed {
    logic signed [QW-1:0] sinr;
    logic signed [QW-1:0] cosr;
    logic signed [QW-1:0] sinp;
    logic signed [QW-1:0] siny;
    logic signed [QW-1:0] cosy;
    logic                 sat;
  } q2e_item_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_tab(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Round a 32-bit binary angle half up to 32-sh bits and keep the low 16 bits.
  function automatic logic [15:0] to_field(input logic [31:0] z, input int sh);
    logic [31:0] r;
    r = z;
    if (sh > 0 && sh < 32) begin
      r = (z + (32'd1 << (sh - 1))) >> sh;
    end
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/q2e_front.sv
// ----------------------------------------------------------------------------
// q2e_front
// Takes an item, forms the component products and the five sine and cosine
// sums, and flags a pitch sine at or beyond one.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_front
  import q2e_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  output logic                    out_vld,
  output q2e_item_t               out_item
);

  logic               vld1;
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  q2e_item_t          item_next;

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= take;
    end
    p_wx <= quat_w * quat_x;
    p_yz <= quat_y * quat_z;
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_wy <= quat_w * quat_y;
    p_zx <= quat_z * quat_x;
    p_wz <= quat_w * quat_z;
    p_xy <= quat_x * quat_y;
    p_zz <= quat_z * quat_z;
  end

  // Sum stage and saturation check.
  always_comb begin
    item_next.sinr = (QW'(p_wx) + QW'(p_yz)) <<< 1;
    item_next.cosr = ONE_Q28 - ((QW'(p_xx) + QW'(p_yy)) <<< 1);
    item_next.sinp = (QW'(p_wy) - QW'(p_zx)) <<< 1;
    item_next.siny = (QW'(p_wz) + QW'(p_xy)) <<< 1;
    item_next.cosy = ONE_Q28 - ((QW'(p_yy) + QW'(p_zz)) <<< 1);
    item_next.sat  = (item_next.sinp >= ONE_Q28) || (item_next.sinp <= -ONE_Q28);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld1;
    end
    out_item <= item_next;
  end

endmodule

`default_nettype wire

>>> rtl/q2e_queue.sv
// ----------------------------------------------------------------------------
// q2e_queue
// Two-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_queue
  import q2e_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire q2e_item_t push_item,
  output logic           full,
  output logic           pop_vld,
  output q2e_item_t      pop_item
);

  q2e_item_t   mem [0:1];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;
  logic        pop;

  // The back part never stalls, so an entry leaves as soon as it is present.
  assign pop      = (count != 2'd0);
  assign pop_vld  = pop;
  assign pop_item = mem[rptr];
  assign full     = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      mem[wptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/q2e_isqrt.sv
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pipelined truncating square root, one result bit per stage, with a
// side band that travels along.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_isqrt
  import q2e_pkg::*;
#(
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] in_n,
  input  wire logic [SW-1:0] in_side,
  output logic               out_vld,
  output logic [RW-1:0]      out_root,
  output logic [SW-1:0]      out_side
);

  logic [NW-1:0] nn   [0:RW];
  logic [RW+1:0] rem  [0:RW];
  logic [RW-1:0] root [0:RW];
  logic [SW-1:0] side [0:RW];
  logic          vld  [0:RW];

  assign nn[0]   = in_n;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;
  assign vld[0]  = in_vld;

  // One digit of the restoring recurrence per stage.
  for (genvar k = 1; k <= RW; k++) begin : g_stage
    logic [RW+3:0] cur;
    logic [RW+3:0] trial;
    assign cur   = {rem[k-1], nn[k-1][NW-1 -: 2]};
    assign trial = cur - {2'b00, root[k-1], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      nn[k]   <= nn[k-1] << 2;
      side[k] <= side[k-1];
      if (!trial[RW+3]) begin
        rem[k]  <= trial[RW+1:0];
        root[k] <= {root[k-1][RW-2:0], 1'b1};
      end else begin
        rem[k]  <= cur[RW+1:0];
        root[k] <= {root[k-1][RW-2:0], 1'b0};
      end
    end
  end

  assign out_vld  = vld[RW];
  assign out_root = root[RW];
  assign out_side = side[RW];

endmodule

`default_nettype wire

>>> rtl/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) as a 32-bit binary angle.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic
  import q2e_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_vld,
  input  wire logic signed [QW-1:0] in_y,
  input  wire logic signed [QW-1:0] in_x,
  output logic                      out_vld,
  output logic [31:0]               angle
);

  logic signed [CW-1:0] xs [0:STEPS];
  logic signed [CW-1:0] ys [0:STEPS];
  logic [31:0]          zs [0:STEPS];
  logic                 zf [0:STEPS];
  logic                 vs [0:STEPS];
  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;

  assign xe = CW'(in_x);
  assign ye = CW'(in_y);

  // Move a left half-plane vector into the right half plane.
  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else begin
      vs[0] <= in_vld;
    end
    zf[0] <= (in_x == '0) && (in_y == '0);
    if (in_x < 0) begin
      if (in_y >= 0) begin
        xs[0] <= ye;
        ys[0] <= -xe;
        zs[0] <= HALF_PI_BA;
      end else begin
        xs[0] <= -ye;
        ys[0] <= xe;
        zs[0] <= 32'd0 - HALF_PI_BA;
      end
    end else begin
      xs[0] <= xe;
      ys[0] <= ye;
      zs[0] <= 32'd0;
    end
  end

  // Micro-rotations, one per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] xsh;
    logic signed [CW-1:0] ysh;
    assign xsh = xs[i] >>> i;
    assign ysh = ys[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else begin
        vs[i+1] <= vs[i];
      end
      zf[i+1] <= zf[i];
      if (ys[i] > 0) begin
        xs[i+1] <= xs[i] + ysh;
        ys[i+1] <= ys[i] - xsh;
        zs[i+1] <= zs[i] + atan_tab(5'(i));
      end else begin
        xs[i+1] <= xs[i] - ysh;
        ys[i+1] <= ys[i] + xsh;
        zs[i+1] <= zs[i] - atan_tab(5'(i));
      end
    end
  end

  assign out_vld = vs[STEPS];
  assign angle   = zf[STEPS] ? 32'd0 : zs[STEPS];

endmodule

`default_nettype wire

>>> rtl/q2e_back.sv
// ----------------------------------------------------------------------------
// q2e_back
// Carries out an item: pitch cosine by square root, three CORDIC
// arctangents, rounding and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_back
  import q2e_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_vld,
  input  wire q2e_item_t   in_item,
  output logic             done,
  output logic [15:0]      roll_angle,
  output logic [15:0]      pitch_angle,
  output logic [15:0]      yaw_angle,
  output logic             pitch_saturated
);

  localparam int SH = 32 - ANGLE_BITS;
  localparam int IW = $bits(q2e_item_t);

  logic              sq_vld;
  q2e_item_t         sq_item;
  logic [NW-1:0]     sq;
  logic [NW-1:0]     rad;
  logic              rt_vld;
  logic [RW-1:0]     rt;
  logic [IW-1:0]     rt_side;
  q2e_item_t         rt_item;
  logic [1:0]        dly [0:CORDIC_STEPS];
  logic              pv;
  logic [31:0]       roll_z, pitch_z, yaw_z;
  logic [31:0]       sat_z;

  // Square of the pitch sine; only its low bits matter when not saturated.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else begin
      sq_vld <= in_vld;
    end
    sq_item <= in_item;
    sq      <= NW'($signed(in_item.sinp[RW-1:0]) * $signed(in_item.sinp[RW-1:0]));
  end

  assign rad = (NW'(1) << 56) - sq;

  q2e_isqrt #(.SW(IW)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sq_vld),
    .in_n     (rad),
    .in_side  (sq_item),
    .out_vld  (rt_vld),
    .out_root (rt),
    .out_side (rt_side)
  );

  assign rt_item = q2e_item_t'(rt_side);

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk (clk), .rst (rst), .in_vld (rt_vld),
    .in_y (rt_item.sinr), .in_x (rt_item.cosr),
    .out_vld (), .angle (roll_z)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk (clk), .rst (rst), .in_vld (rt_vld),
    .in_y (rt_item.sinp), .in_x ($signed({{(QW-RW){1'b0}}, rt})),
    .out_vld (pv), .angle (pitch_z)
  );

  q2e_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk (clk), .rst (rst), .in_vld (rt_vld),
    .in_y (rt_item.siny), .in_x (rt_item.cosy),
    .out_vld (), .angle (yaw_z)
  );

  // Saturation flag and sine sign, delayed to match the CORDIC.
  always_ff @(posedge clk) begin
    dly[0] <= {rt_item.sat, rt_item.sinp[QW-1]};
  end
  for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_dly
    always_ff @(posedge clk) begin
      dly[k] <= dly[k-1];
    end
  end

  assign sat_z = dly[CORDIC_STEPS][0] ? (32'd0 - HALF_PI_BA) : HALF_PI_BA;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pv;
    end
    roll_angle      <= to_field(roll_z, SH);
    yaw_angle       <= to_field(yaw_z, SH);
    pitch_angle     <= to_field(dly[CORDIC_STEPS][1] ? sat_z : pitch_z, SH);
    pitch_saturated <= dly[CORDIC_STEPS][1];
  end

endmodule

`default_nettype wire

>>> rtl/quaternion_to_euler_core.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_core
// Converts a Q1.14 unit quaternion to ZYX Euler angles as binary angles.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the square root and CORDIC units are fully
// pipelined, one bit or one micro-rotation per stage.
// Reset: synchronous rst empties the pipeline and the queue; busy is high
// during reset. Results cannot be stalled by the receiver.
`default_nettype none

module quaternion_to_euler_core
  import q2e_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] quat_w,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  output logic                    done,
  output logic signed [15:0]      roll_angle,
  output logic signed [15:0]      pitch_angle,
  output logic signed [15:0]      yaw_angle,
  output logic                    pitch_saturated
);

  localparam int LAT = 35 + CORDIC_STEPS;

  logic      take;
  logic      f_vld;
  q2e_item_t f_item;
  logic      q_full;
  logic      q_vld;
  q2e_item_t q_item;

  assign busy = rst | q_full;
  assign take = start & ~busy;

  q2e_front u_front (
    .clk (clk), .rst (rst), .take (take),
    .quat_w (quat_w), .quat_x (quat_x), .quat_y (quat_y), .quat_z (quat_z),
    .out_vld (f_vld), .out_item (f_item)
  );

  q2e_queue u_queue (
    .clk (clk), .rst (rst),
    .push (f_vld), .push_item (f_item), .full (q_full),
    .pop_vld (q_vld), .pop_item (q_item)
  );

  q2e_back #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_back (
    .clk (clk), .rst (rst),
    .in_vld (q_vld), .in_item (q_item),
    .done (done),
    .roll_angle (roll_angle), .pitch_angle (pitch_angle),
    .yaw_angle (yaw_angle), .pitch_saturated (pitch_saturated)
  );

  // Every result comes from an item that was taken earlier.
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, LAT))
    else $error("result without a matching item");

  // A saturated pitch is exactly plus or minus a quarter turn.
  a_sat_pitch: assert property (@(posedge clk) disable iff (rst)
    (done && pitch_saturated) |->
      (pitch_angle == to_field(HALF_PI_BA, 32 - ANGLE_BITS)) ||
      (pitch_angle == to_field(32'd0 - HALF_PI_BA, 32 - ANGLE_BITS)))
    else $error("saturated pitch is not a quarter turn");

  // The queue never fills, since the back part drains it every cycle.
  a_never_full: assert property (@(posedge clk) disable iff (rst)
    !q_full)
    else $error("item queue filled");

endmodule

`default_nettype wire
